// ===== hdl/tcp_tahoe_congestion_window_macros.svh =====
// Assertion helpers shared by the congestion window RTL.
`ifndef TCP_TAHOE_CONGESTION_WINDOW_MACROS_SVH
`define TCP_TAHOE_CONGESTION_WINDOW_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcw assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcw assertion failed");

`endif

// ===== hdl/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

    // Event codes
    localparam logic [1:0] CMD_ACK  = 2'd0;
    localparam logic [1:0] CMD_DUP  = 2'd1;
    localparam logic [1:0] CMD_RTO  = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Retransmit request codes
    localparam logic [1:0] REXMIT_NONE = 2'd0;
    localparam logic [1:0] REXMIT_FAST = 2'd1;
    localparam logic [1:0] REXMIT_RTO  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_SEG_SIZE      = 2'd0;
    localparam logic [1:0] REG_DUP_THRESHOLD = 2'd1;
    localparam logic [1:0] REG_INIT_WINDOW   = 2'd2;
    localparam logic [1:0] REG_INIT_THRESH   = 2'd3;

    // Reset values
    localparam logic [15:0] SEG_SIZE_RST      = 16'd536;
    localparam logic [7:0]  DUP_THRESHOLD_RST = 8'd3;
    localparam logic [31:0] INIT_WINDOW_RST   = 32'd536;
    localparam logic [31:0] INIT_THRESH_RST   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] flight_bytes;
        logic [15:0] peak_packets_out;
        logic [15:0] dup_count;
        logic        timer_abort;
    } t_in;

    typedef struct packed {
        logic [31:0] window;
        logic [31:0] threshold;
        logic [1:0]  retransmit;
        logic        try_send;
        logic        after_timeout;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } t_state;

    // Divider control and status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

// ===== hdl/tcw_div.sv =====
`timescale 1ns / 1ps

// Bit-serial restoring divider: one quotient bit per cycle.
module tcw_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcw_pkg::t_div_ctl   i_ctl,
    input  logic [31:0]         i_dividend,
    input  logic [31:0]         i_divisor,
    output tcw_pkg::t_div_sts   o_sts,
    output logic [31:0]         o_quotient
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;

    logic [32:0] w_shift;
    logic [32:0] w_diff;
    logic        w_ge;
    logic [31:0] n_rem;
    logic [31:0] n_quo;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        w_shift = {r_rem, r_quo[31]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = !w_diff[32];
        n_rem   = w_ge ? w_diff[31:0] : w_shift[31:0];
        n_quo   = {r_quo[30:0], w_ge};
    end

    // Control: busy for 32 steps, then a one-cycle done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd31;
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hdl/tcp_tahoe_congestion_window.sv =====
`timescale 1ns / 1ps

// TCP Tahoe congestion window and slow-start threshold.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one event:
// new ACK, duplicate ACK or retransmit timeout. Each event yields exactly
// one result on the output channel (o_out_valid / i_out_ready / o_out_data)
// with the window and threshold after the event and the retransmit request.
// The block takes one event at a time. Duplicate ACKs, timeouts and unused
// codes go from transfer in straight to the done state. A new ACK in slow
// start passes the multiply state (shared 17x16 multiplier), then compare;
// in congestion avoidance it then waits for the bit-serial divider
// that produces MSS*MSS/cwnd one quotient bit per cycle.
// The next event is taken in the cycle its predecessor's result turns
// valid. The result sits in an output register; the next event is taken
// while it waits. If the receiver stalls, the finished next result is held
// until the register is free. Configuration writes on i_cfg_we load
// registers at once (window and threshold writes also load cwnd and
// ssthresh); they must be made only while the block is idle, which the
// block itself does not enforce. Reset loads the reset register values,
// clears the timeout flag and empties both channels.
module tcp_tahoe_congestion_window (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  tcw_pkg::t_in    i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output tcw_pkg::t_out   o_out_data,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data
);

    `include "tcp_tahoe_congestion_window_macros.svh"

    tcw_pkg::t_state r_state;
    tcw_pkg::t_state n_state;

    // Configuration and protocol state
    logic [15:0] r_seg;
    logic [7:0]  r_dupthr;
    logic [31:0] r_cwnd;
    logic [31:0] r_ssth;
    logic        r_rto;

    // Per-event working registers
    logic        r_ss;
    logic [15:0] r_peak;
    logic [32:0] r_prod;
    logic [1:0]  r_rexmit;
    logic        r_send;

    // Output register
    logic          r_out_valid;
    tcw_pkg::t_out r_out;

    tcw_pkg::t_div_ctl div_ctl;
    tcw_pkg::t_div_sts div_sts;
    logic [31:0]       div_quo;
    logic [31:0]       w_divisor;

    logic        w_accept;
    logic        w_out_free;
    logic        w_restart;
    logic [31:0] w_half;
    logic [31:0] w_two_seg;
    logic [31:0] w_new_thr;
    logic [16:0] w_mul_a;
    logic [32:0] w_prod;
    logic [31:0] w_incr;
    logic [32:0] w_sum;
    logic [31:0] w_sat;
    logic        w_ss_grow;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Restart of slow start: threshold = max(flight/2, 2*MSS)
    always_comb begin
        w_half    = {1'b0, i_in_data.flight_bytes[31:1]};
        w_two_seg = {15'd0, r_seg, 1'b0};
        w_new_thr = (w_half > w_two_seg) ? w_half : w_two_seg;
        w_restart = ((i_in_data.cmd == tcw_pkg::CMD_DUP)
                     && (i_in_data.dup_count == {8'd0, r_dupthr}))
                    || ((i_in_data.cmd == tcw_pkg::CMD_RTO) && !i_in_data.timer_abort);
    end

    // Shared multiplier: 2*peak*MSS for the slow-start gate, MSS*MSS otherwise
    always_comb begin
        w_mul_a = r_ss ? {r_peak, 1'b0} : {1'b0, r_seg};
        w_prod  = {16'd0, w_mul_a} * {17'd0, r_seg};
    end

    // Window growth with saturation
    always_comb begin
        if (r_ss) begin
            w_incr = {16'd0, r_seg};
        end else if (div_quo == 32'd0) begin
            w_incr = 32'd1;
        end else begin
            w_incr = div_quo;
        end
        w_sum     = {1'b0, r_cwnd} + {1'b0, w_incr};
        w_sat     = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
        // cwnd/MSS < 2*peak is the same as cwnd < 2*peak*MSS
        w_ss_grow = {1'b0, r_cwnd} < r_prod;
        w_divisor = (r_cwnd == 32'd0) ? 32'd1 : r_cwnd;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in_data.cmd == tcw_pkg::CMD_ACK) ? tcw_pkg::ST_MUL
                                                                  : tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_MUL: begin
                n_state = tcw_pkg::ST_EVAL;
            end
            tcw_pkg::ST_EVAL: begin
                n_state = r_ss ? tcw_pkg::ST_DONE : tcw_pkg::ST_DIV;
            end
            tcw_pkg::ST_DIV: begin
                if (div_sts.done) begin
                    n_state = tcw_pkg::ST_DONE;
                end
            end
            tcw_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = tcw_pkg::ST_IDLE;
                end
            end
            default: n_state = tcw_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready    = 1'b0;
        div_ctl.start = 1'b0;
        unique case (r_state)
            tcw_pkg::ST_IDLE: o_in_ready    = 1'b1;
            tcw_pkg::ST_EVAL: div_ctl.start = !r_ss;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcw_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration and congestion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg    <= tcw_pkg::SEG_SIZE_RST;
            r_dupthr <= tcw_pkg::DUP_THRESHOLD_RST;
            r_cwnd   <= tcw_pkg::INIT_WINDOW_RST;
            r_ssth   <= tcw_pkg::INIT_THRESH_RST;
            r_rto    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    tcw_pkg::REG_SEG_SIZE:      r_seg    <= i_cfg_data[15:0];
                    tcw_pkg::REG_DUP_THRESHOLD: r_dupthr <= i_cfg_data[7:0];
                    tcw_pkg::REG_INIT_WINDOW:   r_cwnd   <= i_cfg_data;
                    tcw_pkg::REG_INIT_THRESH:   r_ssth   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_accept && w_restart) begin
                r_ssth <= w_new_thr;
                r_cwnd <= {16'd0, r_seg};
                if (i_in_data.cmd == tcw_pkg::CMD_RTO) begin
                    r_rto <= 1'b1;
                end
            end
            if ((r_state == tcw_pkg::ST_EVAL) && r_ss && w_ss_grow) begin
                r_cwnd <= w_sat;
            end
            if ((r_state == tcw_pkg::ST_DIV) && div_sts.done) begin
                r_cwnd <= w_sat;
            end
        end
    end

    // Per-event working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ss   <= r_cwnd < r_ssth;
            r_peak <= i_in_data.peak_packets_out;
            r_send <= i_in_data.cmd == tcw_pkg::CMD_ACK;
            if (!w_restart) begin
                r_rexmit <= tcw_pkg::REXMIT_NONE;
            end else if (i_in_data.cmd == tcw_pkg::CMD_RTO) begin
                r_rexmit <= tcw_pkg::REXMIT_RTO;
            end else begin
                r_rexmit <= tcw_pkg::REXMIT_FAST;
            end
        end
        if (r_state == tcw_pkg::ST_MUL) begin
            r_prod <= w_prod;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == tcw_pkg::ST_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == tcw_pkg::ST_DONE) && w_out_free) begin
            r_out.window        <= r_cwnd;
            r_out.threshold     <= r_ssth;
            r_out.retransmit    <= r_rexmit;
            r_out.try_send      <= r_send;
            r_out.after_timeout <= r_rto;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    tcw_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (r_prod[31:0]),
        .i_divisor  (w_divisor),
        .o_sts      (div_sts),
        .o_quotient (div_quo)
    );

    // Checks
    `TCW_ASSERT_IMPL(a_div_active, i_clk, i_rst_n,
        r_state == tcw_pkg::ST_DIV, div_sts.busy || div_sts.done)
    `TCW_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n,
        w_accept, !o_in_ready)
    `TCW_ASSERT_IMPL(a_rto_flagged, i_clk, i_rst_n,
        o_out_valid && (o_out_data.retransmit == tcw_pkg::REXMIT_RTO),
        o_out_data.after_timeout)
    `TCW_ASSERT_IMPL(a_ack_no_rexmit, i_clk, i_rst_n,
        o_out_valid && o_out_data.try_send,
        o_out_data.retransmit == tcw_pkg::REXMIT_NONE)

endmodule

// ===== test/tcp_tahoe_congestion_window_tb.sv =====
`timescale 1ns / 1ps

module tcp_tahoe_congestion_window_tb;
    import tcw_pkg::*;

    localparam int RESET_CYCLES  = 3;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 18;
    localparam int PHASE_EVENTS  = 56;
    localparam int IDLE_PERCENT  = 12;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 50;
    localparam int CALM_FIRST    = 150;
    localparam int CALM_LAST     = 300;
    localparam int HOLD_AT       = 400;

    typedef enum logic {
        STEP_EVENT,
        STEP_WRITE
    } t_step_kind;

    typedef struct {
        t_step_kind  kind;
        logic [1:0]  idx;
        logic [31:0] value;
        t_in         ev;
        logic        typed;
        t_out        result;
    } t_step;

    // DUT connections
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in         in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out        out_data;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = '0;
    logic [31:0] cfg_data  = '0;

    // Shadow copy of the block's settings and congestion state
    logic [15:0] mss       = SEG_SIZE_RST;
    logic [7:0]  dup_limit = DUP_THRESHOLD_RST;
    logic [31:0] cwnd      = INIT_WINDOW_RST;
    logic [31:0] ssthresh  = INIT_THRESH_RST;
    logic        rto_seen  = 1'b0;

    t_out pending_results[$];
    t_step directed_plan[$];

    int   mismatches     = 0;
    int   results_seen   = 0;
    int   fast_rexmits   = 0;
    int   rto_rexmits    = 0;
    int   settings_used  = 1;
    int   events_by_cmd[4];
    int   cycle_count    = 0;
    logic calm           = 1'b0;
    logic hold_req       = 1'b0;

    tcp_tahoe_congestion_window u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Clock
    initial begin
        forever #10 clk = ~clk;
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d results outstanding",
                 $time, cycle_count, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // Loss response: threshold to half the flight (at least two segments),
    // window back to one segment
    function automatic void restart_slow_start(input logic [31:0] flight);
        logic [31:0] half;
        logic [31:0] two_seg;
        half     = flight >> 1;
        two_seg  = {15'd0, mss, 1'b0};
        ssthresh = (half > two_seg) ? half : two_seg;
        cwnd     = {16'd0, mss};
    endfunction

    // Advance the shadow state by one event and return its result
    function automatic t_out tahoe_update(input t_in ev);
        t_out        r;
        logic [31:0] segs;
        logic [31:0] divisor;
        logic [31:0] incr;
        logic [32:0] twice_peak;
        r = '0;
        case (ev.cmd)
            CMD_ACK: begin
                r.try_send = 1'b1;
                if (cwnd < ssthresh) begin
                    // slow start, only while the sender keeps the window full
                    segs       = (mss != 16'd0) ? cwnd / {16'd0, mss} : 32'hFFFF_FFFF;
                    twice_peak = {16'd0, ev.peak_packets_out, 1'b0};
                    if ({1'b0, segs} < twice_peak)
                        cwnd = sat_add(cwnd, {16'd0, mss});
                end else begin
                    // congestion avoidance
                    divisor = (cwnd != 32'd0) ? cwnd : 32'd1;
                    incr    = ({16'd0, mss} * {16'd0, mss}) / divisor;
                    if (incr == 32'd0)
                        incr = 32'd1;
                    cwnd = sat_add(cwnd, incr);
                end
            end
            CMD_DUP: begin
                if (ev.dup_count == {8'd0, dup_limit}) begin
                    restart_slow_start(ev.flight_bytes);
                    r.retransmit = REXMIT_FAST;
                end
            end
            CMD_RTO: begin
                if (!ev.timer_abort) begin
                    restart_slow_start(ev.flight_bytes);
                    rto_seen     = 1'b1;
                    r.retransmit = REXMIT_RTO;
                end
            end
            default: ;
        endcase
        r.window        = cwnd;
        r.threshold     = ssthresh;
        r.after_timeout = rto_seen;
        return r;
    endfunction

    function automatic t_step ev_row(input logic [1:0] cmd, input logic [31:0] flight,
                                     input logic [15:0] peak, input logic [15:0] dups,
                                     input logic abort_bit, input logic typed,
                                     input t_out result);
        t_step s;
        s.kind                = STEP_EVENT;
        s.idx                 = '0;
        s.value               = '0;
        s.ev.cmd              = cmd;
        s.ev.flight_bytes     = flight;
        s.ev.peak_packets_out = peak;
        s.ev.dup_count        = dups;
        s.ev.timer_abort      = abort_bit;
        s.typed               = typed;
        s.result              = result;
        return s;
    endfunction

    function automatic t_step cfg_row(input logic [1:0] idx, input logic [31:0] value);
        t_step s;
        s.kind   = STEP_WRITE;
        s.idx    = idx;
        s.value  = value;
        s.ev     = '0;
        s.typed  = 1'b0;
        s.result = '0;
        return s;
    endfunction

    // Offer one event and hold it until the transfer; expectation recorded then
    task automatic send_event(input t_in ev, input logic typed, input t_out typed_result);
        t_out predicted;
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (!in_ready);
        predicted = tahoe_update(ev);
        pending_results.push_back(typed ? typed_result : predicted);
        events_by_cmd[ev.cmd]++;
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write enable is left high; the caller drops it after the last write
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        case (idx)
            REG_SEG_SIZE:      mss       = value[15:0];
            REG_DUP_THRESHOLD: dup_limit = value[7:0];
            REG_INIT_WINDOW:   cwnd      = value;
            REG_INIT_THRESH:   ssthresh  = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%08h, actual 0x%08h",
                     $time, label, want, got);
            mismatches++;
        end
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Result checker
    initial begin
        t_out want;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                results_seen++;
                if (out_data.retransmit == REXMIT_FAST)
                    fast_rexmits++;
                if (out_data.retransmit == REXMIT_RTO)
                    rto_rexmits++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, out_data);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("window", want.window, out_data.window);
                    compare_field("threshold", want.threshold, out_data.threshold);
                    compare_field("retransmit", 32'(want.retransmit),
                                  32'(out_data.retransmit));
                    compare_field("try_send", 32'(want.try_send), 32'(out_data.try_send));
                    compare_field("after_timeout", 32'(want.after_timeout),
                                  32'(out_data.after_timeout));
                end
            end
        end
    end

    // Stimulus
    initial begin
        t_in         ev;
        logic        cfg_open;
        logic [3:0]  mask;
        int          pick;
        int          sent;

        cfg_open = 1'b0;
        sent     = 0;
        foreach (events_by_cmd[c])
            events_by_cmd[c] = 0;

        // Directed: reset settings first, then extreme and degenerate settings
        directed_plan.push_back(ev_row(CMD_ACK, 32'd5000, 16'd1, 16'd0, 1'b0, 1'b1,
            t_out'{32'd1072, 32'hFFFF_FFFF, REXMIT_NONE, 1'b1, 1'b0}));
        // window not filled: slow start gate stays shut
        directed_plan.push_back(ev_row(CMD_ACK, 32'd0, 16'd0, 16'd0, 1'b0, 1'b1,
            t_out'{32'd1072, 32'hFFFF_FFFF, REXMIT_NONE, 1'b1, 1'b0}));
        // duplicate count below, above and at the trigger
        directed_plan.push_back(ev_row(CMD_DUP, 32'd9000, 16'd7, 16'd2, 1'b0, 1'b1,
            t_out'{32'd1072, 32'hFFFF_FFFF, REXMIT_NONE, 1'b0, 1'b0}));
        directed_plan.push_back(ev_row(CMD_DUP, 32'd9000, 16'd7, 16'hFFFF, 1'b1, 1'b1,
            t_out'{32'd1072, 32'hFFFF_FFFF, REXMIT_NONE, 1'b0, 1'b0}));
        directed_plan.push_back(ev_row(CMD_DUP, 32'hFFFF_FFFF, 16'hFFFF, 16'd3, 1'b1, 1'b1,
            t_out'{32'd536, 32'h7FFF_FFFF, REXMIT_FAST, 1'b0, 1'b0}));
        // aborted timeout leaves everything alone
        directed_plan.push_back(ev_row(CMD_RTO, 32'd0, 16'd0, 16'd0, 1'b1, 1'b1,
            t_out'{32'd536, 32'h7FFF_FFFF, REXMIT_NONE, 1'b0, 1'b0}));
        directed_plan.push_back(ev_row(CMD_RTO, 32'd0, 16'd0, 16'd0, 1'b0, 1'b1,
            t_out'{32'd536, 32'd1072, REXMIT_RTO, 1'b0, 1'b1}));
        directed_plan.push_back(ev_row(CMD_NONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
            1'b1, t_out'{32'd536, 32'd1072, REXMIT_NONE, 1'b0, 1'b1}));
        directed_plan.push_back(ev_row(CMD_ACK, 32'd0, 16'hFFFF, 16'd0, 1'b0, 1'b1,
            t_out'{32'd1072, 32'd1072, REXMIT_NONE, 1'b1, 1'b1}));
        directed_plan.push_back(ev_row(CMD_ACK, 32'd0, 16'd0, 16'd0, 1'b0, 1'b1,
            t_out'{32'd1340, 32'd1072, REXMIT_NONE, 1'b1, 1'b1}));
        directed_plan.push_back(ev_row(CMD_ACK, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0, '0));
        // largest segment, window near the top: saturation
        directed_plan.push_back(cfg_row(REG_SEG_SIZE, 32'h0000_FFFF));
        directed_plan.push_back(cfg_row(REG_DUP_THRESHOLD, 32'd255));
        directed_plan.push_back(cfg_row(REG_INIT_WINDOW, 32'hFFFF_FFF0));
        directed_plan.push_back(cfg_row(REG_INIT_THRESH, 32'hFFFF_FFFF));
        directed_plan.push_back(ev_row(CMD_ACK, 32'd0, 16'hFFFF, 16'd0, 1'b0, 1'b1,
            t_out'{32'hFFFF_FFFF, 32'hFFFF_FFFF, REXMIT_NONE, 1'b1, 1'b1}));
        directed_plan.push_back(ev_row(CMD_ACK, 32'd0, 16'd0, 16'd0, 1'b0, 1'b1,
            t_out'{32'hFFFF_FFFF, 32'hFFFF_FFFF, REXMIT_NONE, 1'b1, 1'b1}));
        directed_plan.push_back(ev_row(CMD_DUP, 32'd1, 16'd0, 16'd255, 1'b0, 1'b1,
            t_out'{32'd65535, 32'd131070, REXMIT_FAST, 1'b0, 1'b1}));
        directed_plan.push_back(ev_row(CMD_DUP, 32'h8000_0000, 16'h8000, 16'hFF00, 1'b0,
            1'b0, '0));
        // zero segment size, then a zero window in congestion avoidance
        directed_plan.push_back(cfg_row(REG_SEG_SIZE, 32'd0));
        directed_plan.push_back(cfg_row(REG_DUP_THRESHOLD, 32'd1));
        directed_plan.push_back(cfg_row(REG_INIT_WINDOW, 32'd1));
        directed_plan.push_back(cfg_row(REG_INIT_THRESH, 32'hFFFF_FFFF));
        directed_plan.push_back(ev_row(CMD_ACK, 32'd0, 16'hFFFF, 16'd0, 1'b0, 1'b1,
            t_out'{32'd1, 32'hFFFF_FFFF, REXMIT_NONE, 1'b1, 1'b1}));
        directed_plan.push_back(ev_row(CMD_RTO, 32'd1, 16'd0, 16'd0, 1'b0, 1'b1,
            t_out'{32'd0, 32'd0, REXMIT_RTO, 1'b0, 1'b1}));
        directed_plan.push_back(ev_row(CMD_ACK, 32'd0, 16'd0, 16'd0, 1'b0, 1'b1,
            t_out'{32'd1, 32'd0, REXMIT_NONE, 1'b1, 1'b1}));
        directed_plan.push_back(ev_row(CMD_ACK, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0, '0));
        directed_plan.push_back(ev_row(CMD_DUP, 32'h5555_5555, 16'h5555, 16'd1, 1'b0,
            1'b0, '0));
        // smallest window and threshold
        directed_plan.push_back(cfg_row(REG_SEG_SIZE, 32'd1460));
        directed_plan.push_back(cfg_row(REG_DUP_THRESHOLD, 32'd3));
        directed_plan.push_back(cfg_row(REG_INIT_WINDOW, 32'd1));
        directed_plan.push_back(cfg_row(REG_INIT_THRESH, 32'd1));
        directed_plan.push_back(ev_row(CMD_ACK, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0, '0));
        directed_plan.push_back(ev_row(CMD_DUP, 32'h1234_5678, 16'd3, 16'd3, 1'b0,
            1'b0, '0));
        directed_plan.push_back(ev_row(CMD_RTO, 32'hAAAA_AAAA, 16'd2, 16'd3, 1'b1,
            1'b0, '0));
        directed_plan.push_back(ev_row(CMD_ACK, 32'd0, 16'd2, 16'd0, 1'b0, 1'b0, '0));

        // Reset
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[k]) begin
            if (directed_plan[k].kind == STEP_WRITE) begin
                if (!cfg_open) begin
                    drain_results();
                    settings_used++;
                end
                write_reg(directed_plan[k].idx, directed_plan[k].value);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) begin
                    cfg_we   <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_event(directed_plan[k].ev, directed_plan[k].typed,
                           directed_plan[k].result);
            end
        end

        // Random phases; each starts with the sender paused until all results are in
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            mask = (phase == 0) ? 4'hF : 4'($urandom_range(15));
            if (mask[REG_SEG_SIZE]) begin
                case ($urandom_range(4))
                    0: write_reg(REG_SEG_SIZE, 32'd1);
                    1: write_reg(REG_SEG_SIZE, 32'h0000_FFFF);
                    2: write_reg(REG_SEG_SIZE, {16'd0, SEG_SIZE_RST});
                    3: write_reg(REG_SEG_SIZE, 32'd1460);
                    default: write_reg(REG_SEG_SIZE, $urandom_range(1, 65535));
                endcase
            end
            if (mask[REG_DUP_THRESHOLD]) begin
                case ($urandom_range(3))
                    0: write_reg(REG_DUP_THRESHOLD, 32'd1);
                    1: write_reg(REG_DUP_THRESHOLD, 32'd255);
                    2: write_reg(REG_DUP_THRESHOLD, {24'd0, DUP_THRESHOLD_RST});
                    default: write_reg(REG_DUP_THRESHOLD, $urandom_range(1, 255));
                endcase
            end
            if (mask[REG_INIT_WINDOW]) begin
                case ($urandom_range(3))
                    0: write_reg(REG_INIT_WINDOW, 32'd1);
                    1: write_reg(REG_INIT_WINDOW, 32'hFFFF_FFFF);
                    2: write_reg(REG_INIT_WINDOW, mss * $urandom_range(1, 10));
                    default: write_reg(REG_INIT_WINDOW, $urandom);
                endcase
            end
            if (mask[REG_INIT_THRESH]) begin
                case ($urandom_range(3))
                    0: write_reg(REG_INIT_THRESH, 32'd1);
                    1: write_reg(REG_INIT_THRESH, 32'hFFFF_FFFF);
                    2: write_reg(REG_INIT_THRESH, $urandom_range(1, 1 << 20));
                    default: write_reg(REG_INIT_THRESH, $urandom);
                endcase
            end
            if (mask != 4'h0) begin
                cfg_we <= 1'b0;
                settings_used++;
            end

            for (int n = 0; n < PHASE_EVENTS; n++) begin
                // long stretch with no idling on either side
                calm = (sent >= CALM_FIRST && sent < CALM_LAST);
                // receiver holds off while events keep coming
                if (sent == HOLD_AT)
                    hold_req = 1'b1;

                pick = $urandom_range(99);
                if (pick < 55)
                    ev.cmd = CMD_ACK;
                else if (pick < 80)
                    ev.cmd = CMD_DUP;
                else if (pick < 93)
                    ev.cmd = CMD_RTO;
                else
                    ev.cmd = CMD_NONE;

                case ($urandom_range(3))
                    0: ev.flight_bytes = $urandom;
                    1: ev.flight_bytes = mss * $urandom_range(64);
                    2: ev.flight_bytes = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
                    default: ev.flight_bytes = $urandom_range(3);
                endcase

                case ($urandom_range(4))
                    0, 1: ev.peak_packets_out = 16'($urandom_range(40));
                    2: ev.peak_packets_out = 16'($urandom_range(3));
                    3: ev.peak_packets_out = 16'($urandom);
                    default: ev.peak_packets_out = 16'hFFFF;
                endcase

                // often hit the trigger count, sometimes just miss it, else any count
                case ($urandom_range(4))
                    0, 1: ev.dup_count = {8'd0, dup_limit};
                    2: ev.dup_count = {8'd0, dup_limit} + 16'd1;
                    3: ev.dup_count = {8'd0, dup_limit} - 16'd1;
                    default: ev.dup_count = 16'($urandom);
                endcase

                ev.timer_abort = ($urandom_range(99) < 25);
                send_event(ev, 1'b0, '0);
                sent++;
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d events (%0d new ACK, %0d duplicate, %0d timeout, %0d unused)",
                 events_by_cmd[CMD_ACK] + events_by_cmd[CMD_DUP] + events_by_cmd[CMD_RTO]
                 + events_by_cmd[CMD_NONE], events_by_cmd[CMD_ACK], events_by_cmd[CMD_DUP],
                 events_by_cmd[CMD_RTO], events_by_cmd[CMD_NONE]);
        $display("over %0d register settings; %0d results checked, %0d fast, %0d timeout rexmits",
                 settings_used, results_seen, fast_rexmits, rto_rexmits);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
